/* src/assert_macros.svh */
// Assertion macros used by the port-level checker of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PITT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PITT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pitt_pkg.sv */
// Package with the shared types and constants of the point-in-triangle test.
package pitt_pkg;

  // Default coordinate width of the vertices and the query point.
  localparam int COORD_BITS_DEF = 16;

  // Width of the containment result.
  localparam int CONT_W = 2;

  // Containment codes.
  localparam logic signed [CONT_W-1:0] CONT_OUTSIDE = 2'sb00;
  localparam logic signed [CONT_W-1:0] CONT_IN_CCW  = 2'sb01;
  localparam logic signed [CONT_W-1:0] CONT_IN_CW   = 2'sb11;

  // Outcome of one orientation test.
  typedef enum logic [1:0] {
    ORIENT_ZERO = 2'b00,
    ORIENT_POS  = 2'b01,
    ORIENT_NEG  = 2'b10
  } orient_t;

  // Orientation results of edges a-b, b-c and c-a, handed from the lanes to the merge.
  typedef struct packed {
    orient_t ab;
    orient_t bc;
    orient_t ca;
  } orient_set_t;

endpackage

/* src/pitt_ifs.sv */
// Valid/ready channel interfaces for the input item and the result item.
interface pitt_in_if #(
  parameter int COORD_BITS = pitt_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_a_x;
  logic signed [COORD_BITS-1:0] vertex_a_y;
  logic signed [COORD_BITS-1:0] vertex_b_x;
  logic signed [COORD_BITS-1:0] vertex_b_y;
  logic signed [COORD_BITS-1:0] vertex_c_x;
  logic signed [COORD_BITS-1:0] vertex_c_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, query_x, query_y,
    output ready
  );
endinterface

interface pitt_out_if ();
  logic                                   valid;
  logic                                   ready;
  logic signed [pitt_pkg::CONT_W-1:0]     containment;

  modport source (output valid, containment, input ready);
  modport sink (input valid, containment, output ready);
endinterface

/* src/point_in_triangle_test.sv */
// Top level of the point-in-triangle containment test.
// Usage:
//   The input channel in_ch carries one item per handshake: three triangle
//   vertices a, b, c and a query point, all signed COORD_BITS-bit values.
//   The result channel out_ch returns one item per input item, in order:
//   1 for inside counterclockwise or on an edge, -1 for inside clockwise,
//   and 0 for outside.
//   Three lanes test edge a-b, b-c and c-a against the query point side by
//   side (differences, exact products, orientation), and a merge stage
//   combines the three orientations into the output register.
// Pipeline:
//   A result passes four register stages from input to output. The
//   pipeline advances whenever the output register is free or being taken,
//   so one item can be accepted every cycle while the output does not stall.
// Reset:
//   rst_n is synchronous and active low; it empties the pipeline.
// Stall:
//   While a result waits with out_ch.ready low, the whole pipeline freezes
//   and in_ch.ready is low; otherwise in_ch.ready is high.
module point_in_triangle_test #(
  parameter int COORD_BITS = pitt_pkg::COORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  pitt_in_if.sink    in_ch,
  pitt_out_if.source out_ch
);

  // Pipeline advance: the output register is free or its item is taken now.
  logic adv;
  logic out_valid;

  // Valid bits of the lane stages (differences, products, orientation).
  logic v1_r, v2_r, v3_r;

  pitt_pkg::orient_set_t orients;

  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Edge a-b against the query point.
  pitt_lane #(.COORD_BITS(COORD_BITS)) u_lane_ab (
    .clk    (clk),
    .en     (adv),
    .s_x    (in_ch.vertex_a_x),
    .s_y    (in_ch.vertex_a_y),
    .e_x    (in_ch.vertex_b_x),
    .e_y    (in_ch.vertex_b_y),
    .p_x    (in_ch.query_x),
    .p_y    (in_ch.query_y),
    .orient (orients.ab)
  );

  // Edge b-c against the query point.
  pitt_lane #(.COORD_BITS(COORD_BITS)) u_lane_bc (
    .clk    (clk),
    .en     (adv),
    .s_x    (in_ch.vertex_b_x),
    .s_y    (in_ch.vertex_b_y),
    .e_x    (in_ch.vertex_c_x),
    .e_y    (in_ch.vertex_c_y),
    .p_x    (in_ch.query_x),
    .p_y    (in_ch.query_y),
    .orient (orients.bc)
  );

  // Edge c-a against the query point.
  pitt_lane #(.COORD_BITS(COORD_BITS)) u_lane_ca (
    .clk    (clk),
    .en     (adv),
    .s_x    (in_ch.vertex_c_x),
    .s_y    (in_ch.vertex_c_y),
    .e_x    (in_ch.vertex_a_x),
    .e_y    (in_ch.vertex_a_y),
    .p_x    (in_ch.query_x),
    .p_y    (in_ch.query_y),
    .orient (orients.ca)
  );

  // The merge owns the output register and its valid bit.
  pitt_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .valid_in    (v3_r),
    .orients     (orients),
    .out_valid   (out_valid),
    .containment (out_ch.containment)
  );

  assign out_ch.valid = out_valid;

endmodule

/* src/pitt_lane.sv */
// One orientation-test lane: differences, exact products, then sign decision.
module pitt_lane #(
  parameter int COORD_BITS = pitt_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] s_x,
  input  logic signed [COORD_BITS-1:0] s_y,
  input  logic signed [COORD_BITS-1:0] e_x,
  input  logic signed [COORD_BITS-1:0] e_y,
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  output pitt_pkg::orient_t            orient
);

  localparam int DW = COORD_BITS + 1;       // difference width
  localparam int PW = 2 * COORD_BITS + 2;   // signed product width
  localparam int SW = 2 * COORD_BITS + 1;   // square width
  localparam int LW = 2 * COORD_BITS + 2;   // squared length width

  // Stage 1: edge and point differences.
  logic signed [DW-1:0] dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [DW-1:0] dx1_nxt, dy1_nxt, dx2_nxt, dy2_nxt;

  // Stage 2: cross products, squares and the opposite-direction flag.
  logic signed [PW-1:0] lhs_r, rhs_r, lhs_nxt, rhs_nxt;
  logic signed [PW-1:0] sq_dx1_full, sq_dy1_full, sq_dx2_full, sq_dy2_full;
  logic [SW-1:0]        sq_dx1_r, sq_dy1_r, sq_dx2_r, sq_dy2_r;
  logic                 opp_r, opp_nxt;

  // Stage 3: orientation code.
  logic [LW-1:0]        len1, len2;
  pitt_pkg::orient_t    orient_r, orient_nxt;

  assign dx1_nxt = DW'(e_x) - DW'(s_x);
  assign dy1_nxt = DW'(e_y) - DW'(s_y);
  assign dx2_nxt = DW'(p_x) - DW'(s_x);
  assign dy2_nxt = DW'(p_y) - DW'(s_y);

  assign lhs_nxt     = PW'(dx1_r) * PW'(dy2_r);
  assign rhs_nxt     = PW'(dy1_r) * PW'(dx2_r);
  assign sq_dx1_full = PW'(dx1_r) * PW'(dx1_r);
  assign sq_dy1_full = PW'(dy1_r) * PW'(dy1_r);
  assign sq_dx2_full = PW'(dx2_r) * PW'(dx2_r);
  assign sq_dy2_full = PW'(dy2_r) * PW'(dy2_r);

  // Opposite directions: in x or in y, both components nonzero with differing signs.
  assign opp_nxt = ((dx1_r != '0) && (dx2_r != '0) && (dx1_r[DW-1] != dx2_r[DW-1])) ||
                   ((dy1_r != '0) && (dy2_r != '0) && (dy1_r[DW-1] != dy2_r[DW-1]));

  assign len1 = {1'b0, sq_dx1_r} + {1'b0, sq_dy1_r};
  assign len2 = {1'b0, sq_dx2_r} + {1'b0, sq_dy2_r};

  always_comb begin
    priority if (lhs_r > rhs_r) begin
      orient_nxt = pitt_pkg::ORIENT_POS;
    end else if (lhs_r < rhs_r) begin
      orient_nxt = pitt_pkg::ORIENT_NEG;
    end else if (opp_r) begin
      orient_nxt = pitt_pkg::ORIENT_NEG;
    end else if (len1 < len2) begin
      orient_nxt = pitt_pkg::ORIENT_POS;
    end else begin
      orient_nxt = pitt_pkg::ORIENT_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r    <= dx1_nxt;
      dy1_r    <= dy1_nxt;
      dx2_r    <= dx2_nxt;
      dy2_r    <= dy2_nxt;
      lhs_r    <= lhs_nxt;
      rhs_r    <= rhs_nxt;
      sq_dx1_r <= sq_dx1_full[SW-1:0];
      sq_dy1_r <= sq_dy1_full[SW-1:0];
      sq_dx2_r <= sq_dx2_full[SW-1:0];
      sq_dy2_r <= sq_dy2_full[SW-1:0];
      opp_r    <= opp_nxt;
      orient_r <= orient_nxt;
    end
  end

  assign orient = orient_r;

endmodule

/* src/pitt_merge.sv */
// Merge stage: combines the orientations of edges a-b, b-c and c-a into the result register.
module pitt_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               valid_in,
  input  pitt_pkg::orient_set_t              orients,
  output logic                               out_valid,
  output logic signed [pitt_pkg::CONT_W-1:0] containment
);

  logic                               valid_r;
  logic signed [pitt_pkg::CONT_W-1:0] cont_r, cont_nxt;

  // Tests are judged in edge order; a point on an edge counts as inside.
  always_comb begin
    priority if ((orients.ab == pitt_pkg::ORIENT_ZERO) ||
                 (orients.bc == pitt_pkg::ORIENT_ZERO)) begin
      cont_nxt = pitt_pkg::CONT_IN_CCW;
    end else if (orients.bc != orients.ab) begin
      cont_nxt = pitt_pkg::CONT_OUTSIDE;
    end else if (orients.ca == pitt_pkg::ORIENT_ZERO) begin
      cont_nxt = pitt_pkg::CONT_IN_CCW;
    end else if (orients.ca != orients.ab) begin
      cont_nxt = pitt_pkg::CONT_OUTSIDE;
    end else if (orients.ab == pitt_pkg::ORIENT_POS) begin
      cont_nxt = pitt_pkg::CONT_IN_CCW;
    end else begin
      cont_nxt = pitt_pkg::CONT_IN_CW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cont_r <= cont_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign containment = cont_r;

endmodule

/* src/pitt_checker.sv */
// Port-level checker for the point-in-triangle test and its bind statement.
`include "assert_macros.svh"

module pitt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [pitt_pkg::CONT_W-1:0] containment
);

  // A result is waiting and the receiver holds it off.
  logic stalled;

  assign stalled = out_valid && !out_ready;

  // A waiting result keeps its value until it is taken.
  `PITT_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(containment), "result moved")

  // The code -2 (bit pattern 10) is never produced.
  `PITT_ASSERT(a_cont_legal, !out_valid || (containment != 2'sb10), "illegal containment code")

  // With no result waiting the input side must be open.
  `PITT_ASSERT(a_ready_when_empty, out_valid || in_ready, "input blocked with empty output")

  // The input side closes only behind a stalled result.
  `PITT_ASSERT(a_block_only_stalled, in_ready || stalled, "input blocked without a stall")

endmodule

bind point_in_triangle_test pitt_checker u_pitt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .containment (out_ch.containment)
);
